FILE: rtl/core/ovl_pkg.sv
package ovl_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int POSITION_W = 4;
  localparam int TOTAL_W    = 5;
  localparam int IN_VALUE_W = 32;

  // per-cell control for the update cycle
  typedef struct packed {
    logic insert;    // append operand at the tail cell
    logic remove;    // shift toward head from the first match onward
    logic occupied;  // cell index below the entry count
    logic tail;      // cell index equals the entry count
  } cell_ctl_t;

endpackage

FILE: rtl/core/ovl_cell.sv
module ovl_cell
  import ovl_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [VALUE_WIDTH-1:0] operand,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic                   seen_in,
  output logic [VALUE_WIDTH-1:0] stored,
  output logic                   match,
  output logic                   seen_out
);

  assign match    = ctl.occupied && (stored == operand);
  assign seen_out = seen_in | match;

  always_ff @(posedge clk) begin
    if (ctl.insert && ctl.tail) begin
      stored <= operand;
    end else if (ctl.remove && seen_out) begin
      stored <= right_value;
    end
  end

endmodule

FILE: rtl/core/ordered_value_list.sv
// Ordered value list: a bounded list of signed words kept in arrival order.
// Input channel (in_valid / in_stall) carries action and value; a transfer
// happens when in_valid is high and in_stall is low. Output channel
// (out_valid / out_stall) returns status, found, position and entry_total,
// one result per input item.
// Each item is handled in order: the transfer edge latches the operation;
// then, in the update cycle, every cell compares its entry with the operand at
// once, the first-match flag ripples down the cell row, and at the end of that
// cycle the row shifts or appends and the result is loaded into the output register.
// in_stall is high while an item is in flight, so no new item is accepted until it finishes.
// If the receiver stalls, the result waits in the output register; a new
// item may still be accepted, but it holds in its update cycle until the
// output register frees.
// Reset (rst, synchronous) empties the list and drops any pending result;
// cell contents are not cleared.
module ordered_value_list
  import ovl_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic signed [IN_VALUE_W-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic                         found,
  output logic [POSITION_W-1:0]        position,
  output logic [TOTAL_W-1:0]           entry_total
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic                   busy;
  logic [1:0]             op_action;
  logic [VALUE_WIDTH-1:0] op_value;
  logic [VALUE_WIDTH-1:0] operand_in;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   finish;

  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY:0]      seen;
  cell_ctl_t              ctl [CAPACITY];

  logic                   hit;
  logic [IDX_W-1:0]       hit_pos;
  logic                   do_insert;
  logic                   do_remove;
  logic [1:0]             status_next;

  generate
    if (VALUE_WIDTH <= IN_VALUE_W) begin : g_narrow
      assign operand_in = value[VALUE_WIDTH-1:0];
    end else begin : g_wide
      assign operand_in = {{(VALUE_WIDTH-IN_VALUE_W){1'b0}}, value};
    end
  endgenerate

  assign in_stall = busy;
  assign finish   = busy && (!out_valid || !out_stall);

  assign seen[0] = 1'b0;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] right;

      if (i == CAPACITY - 1) begin : g_last
        assign right = cell_value[i];
      end else begin : g_mid
        assign right = cell_value[i+1];
      end

      assign ctl[i].insert   = finish && do_insert;
      assign ctl[i].remove   = finish && do_remove;
      assign ctl[i].occupied = CNT_W'(i) < count;
      assign ctl[i].tail     = CNT_W'(i) == count;

      ovl_cell #(
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl[i]),
        .operand    (op_value),
        .right_value(right),
        .seen_in    (seen[i]),
        .stored     (cell_value[i]),
        .match      (match[i]),
        .seen_out   (seen[i+1])
      );
    end
  endgenerate

  assign hit = seen[CAPACITY];

  // only the first match has no match ahead of it
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i] && !seen[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
      end
    end
  end

  always_comb begin
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    status_next = ST_OK;
    count_next  = count;
    unique case (op_action)
      ACT_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          do_insert  = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_REMOVE, ACT_SEARCH: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (!hit) begin
          status_next = ST_NOT_FOUND;
        end else if (op_action == ACT_REMOVE) begin
          do_remove  = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        busy      <= 1'b1;
        op_action <= action;
        op_value  <= operand_in;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status      <= status_next;
      found       <= (op_action == ACT_REMOVE || op_action == ACT_SEARCH) &&
                     count != '0 && hit;
      position    <= ((op_action == ACT_REMOVE || op_action == ACT_SEARCH) && hit)
                     ? POSITION_W'(hit_pos) : '0;
      entry_total <= TOTAL_W'(count_next);
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> busy)
    else $error("accepted item did not start");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("finished item left no result");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !finish |=> $stable(count))
    else $error("entry count changed outside the update cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> status == ST_OK)
    else $error("found reported with a fault status");

endmodule

FILE: test/ordered_value_list_test.sv
`timescale 1ns / 1ps

module ordered_value_list_test;
  import ovl_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int LIST_DEPTH    = 16;
  localparam int RANDOM_ITEMS  = 900;
  localparam int PHASE_COUNT   = 4;
  localparam int POOL_SIZE     = 8;
  localparam int LONG_HOLD     = 100;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [1:0]            act;
    logic [IN_VALUE_W-1:0] val;
  } list_op_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic [POSITION_W-1:0] position;
    logic [TOTAL_W-1:0]    entry_total;
  } list_result_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic [1:0]                   action    = ACT_INSERT;
  logic signed [IN_VALUE_W-1:0] value     = '0;
  logic                         out_stall = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic [1:0]                   status;
  logic                         found;
  logic [POSITION_W-1:0]        position;
  logic [TOTAL_W-1:0]           entry_total;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];

  // predictor's copy of the list
  logic [IN_VALUE_W-1:0] list_cells[LIST_DEPTH];
  int                    list_len = 0;

  logic [IN_VALUE_W-1:0] value_pool[POOL_SIZE];
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_kick      = 1'b0;
  int   hold_left      = 0;
  int   mismatches     = 0;
  int   cycle_count    = 0;

  ordered_value_list #(
    .CAPACITY    (LIST_DEPTH),
    .VALUE_WIDTH (IN_VALUE_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .position    (position),
    .entry_total (entry_total)
  );

  always #5 clk = ~clk;

  function automatic list_result_t apply_list_op(input logic [1:0] act,
                                                 input logic [IN_VALUE_W-1:0] val);
    list_result_t r;
    int           hit;
    r        = '0;
    r.status = ST_OK;
    hit      = -1;
    case (act)
      ACT_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_cells[list_len] = val;
          list_len++;
        end
      end
      ACT_REMOVE, ACT_SEARCH: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // scan from the tail so the head-most match wins
          for (int i = list_len - 1; i >= 0; i--)
            if (list_cells[i] == val) hit = i;
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.found    = 1'b1;
            r.position = hit[POSITION_W-1:0];
            if (act == ACT_REMOVE) begin
              for (int j = hit; j < list_len - 1; j++)
                list_cells[j] = list_cells[j + 1];
              list_len--;
            end
          end
        end
      end
      default: ;
    endcase
    r.entry_total = list_len[TOTAL_W-1:0];
    return r;
  endfunction

  // driver: one transfer per accepted item, prediction taken at the transfer edge
  always @(posedge clk) begin : drive
    list_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(apply_list_op(action, value));
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = pending_ops.pop_front();
          in_valid <= 1'b1;
          action   <= op.act;
          value    <= op.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {status, found, position, entry_total};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result at cycle %0d: status %0d found %0b position %0d total %0d",
                     cycle_count, got.status, got.found, got.position, got.entry_total);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $write("mismatch at cycle %0d: expected status %0d found %0b position %0d",
                     cycle_count, want.status, want.found, want.position);
              $display(" total %0d, got status %0d found %0b position %0d total %0d",
                       want.entry_total, got.status, got.found, got.position,
                       got.entry_total);
            end
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_op(input logic [1:0] act, input logic [IN_VALUE_W-1:0] val);
    pending_ops.push_back('{act: act, val: val});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    int                    ins_pct;
    int                    pick;
    logic [1:0]            act;
    logic [IN_VALUE_W-1:0] val;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, duplicates, head removal, misses, an unused action, fill to full
    queue_op(ACT_SEARCH, 32'd0);
    queue_op(ACT_REMOVE, 32'd0);
    queue_op(ACT_INSERT, 32'h8000_0000);
    queue_op(ACT_INSERT, 32'h7fff_ffff);
    queue_op(ACT_INSERT, 32'hffff_ffff);
    queue_op(ACT_INSERT, 32'd5);
    queue_op(ACT_INSERT, 32'd5);
    queue_op(ACT_SEARCH, 32'd5);
    queue_op(ACT_REMOVE, 32'h8000_0000);
    queue_op(ACT_REMOVE, 32'd5);
    queue_op(ACT_SEARCH, 32'd5);
    queue_op(ACT_SEARCH, 32'd1234);
    queue_op(ACT_REMOVE, 32'd1234);
    queue_op(ACT_UNUSED, $urandom);
    for (int i = 0; i < LIST_DEPTH - 3; i++)
      queue_op(ACT_INSERT, 32'd100 + i);
    queue_op(ACT_INSERT, 32'd999);
    queue_op(ACT_SEARCH, 32'd112);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      for (int k = 2; k < POOL_SIZE; k++)
        value_pool[k] = $urandom;
      for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
        // alternate filling and draining stretches so full and empty both occur
        ins_pct = ((n / 40) % 2 == 0) ? 70 : 20;
        pick = $urandom_range(99);
        if (pick < 3)
          act = ACT_UNUSED;
        else if (pick < 3 + ins_pct)
          act = ACT_INSERT;
        else if ($urandom_range(1) == 0)
          act = ACT_REMOVE;
        else
          act = ACT_SEARCH;
        pick = $urandom_range(99);
        if (pick < 60)
          val = value_pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 75)
          val = $urandom_range(7);
        else
          val = $urandom;
        queue_op(act, val);
      end
      if (p == 0) begin
        repeat (8) @(negedge clk);
        hold_kick = 1'b1;
        @(negedge clk);
        hold_kick = 1'b0;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ovl_pkg.sv
rtl/core/ovl_cell.sv
rtl/core/ordered_value_list.sv
test/ordered_value_list_test.sv
